// File: rtl/core/fhm_pkg.sv
// ----------------------------------------------------------------------------
// fhm_pkg
// shared widths and result codes of the queued mutex
// ----------------------------------------------------------------------------
package fhm_pkg;

  localparam int unsigned TASKS_DEF = 16;
  localparam int unsigned TASK_W    = 4;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_HANDOFF  = 3'd2,
    ST_FREED    = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_DROPPED  = 3'd5
  } status_t;

  typedef enum logic {
    REQ_LOCK   = 1'b0,
    REQ_UNLOCK = 1'b1
  } req_t;

endpackage

// File: rtl/core/fifo_handoff_mutex.sv
// ----------------------------------------------------------------------------
// fifo_handoff_mutex
// hardware mutex with a ring of waiting tasks and direct ownership handoff
// ----------------------------------------------------------------------------
// Each request passes through S_IDLE and S_EXEC: the wait ring is held in a
// synchronous memory, so S_IDLE reads the entry at the ring head and S_EXEC
// applies the lock or unlock, writes the ring tail when a task is
// queued and loads the result register. A new request is taken as soon as the
// previous one has been applied, even while its result still waits to be
// taken; the apply cycle then holds until the result register is free.
// A lock on a held mutex is dropped with status 5 when TASKS tasks already wait.
module fifo_handoff_mutex #(
  parameter int unsigned TASKS = fhm_pkg::TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] task_id, [7:4] zero
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [6:3] woken_task,
                                  // [10:7] owner_task, [11] is_locked,
                                  // [15:12] zero
);

  localparam int unsigned PTR_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(TASKS + 1);
  localparam int unsigned TW    = fhm_pkg::TASK_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t               state_r;
  logic                 held_r;
  logic [TW-1:0]        owner_r;
  logic [PTR_W-1:0]     head_r;
  logic [PTR_W-1:0]     tail_r;
  logic [CNT_W-1:0]     count_r;

  logic                 req_unlock_r;
  logic [TW-1:0]        req_task_r;
  logic [TW-1:0]        rd_data_r;

  logic [TW-1:0]        mem [TASKS];

  logic                 out_valid_r;
  fhm_pkg::status_t     out_status_r;
  logic [TW-1:0]        out_woken_r;
  logic [TW-1:0]        out_owner_r;
  logic                 out_locked_r;

  logic                 in_fire;
  logic                 exec_go;
  logic                 mem_we;
  fhm_pkg::status_t     status_nxt;
  logic                 held_nxt;
  logic [TW-1:0]        owner_nxt;
  logic [TW-1:0]        woken_nxt;
  logic [PTR_W-1:0]     head_nxt;
  logic [PTR_W-1:0]     tail_nxt;
  logic [CNT_W-1:0]     count_nxt;
  logic                 ring_full;
  logic                 ring_empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] n;
    n = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
    return (n == (PTR_W+1)'(TASKS)) ? '0 : n[PTR_W-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign ring_full  = (count_r == CNT_W'(TASKS));
  assign ring_empty = (count_r == '0);

  always_comb begin
    status_nxt = fhm_pkg::ST_IGNORED;
    held_nxt   = held_r;
    owner_nxt  = owner_r;
    woken_nxt  = '0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    if (!req_unlock_r) begin
      if (!held_r) begin
        held_nxt   = 1'b1;
        owner_nxt  = req_task_r;
        status_nxt = fhm_pkg::ST_ACQUIRED;
      end else if (ring_full) begin
        status_nxt = fhm_pkg::ST_DROPPED;
      end else begin
        mem_we     = 1'b1;
        tail_nxt   = ptr_inc(tail_r);
        count_nxt  = count_r + CNT_W'(1);
        status_nxt = fhm_pkg::ST_QUEUED;
      end
    end else begin
      if (!held_r || owner_r != req_task_r) begin
        status_nxt = fhm_pkg::ST_IGNORED;
      end else if (!ring_empty) begin
        woken_nxt  = rd_data_r;
        owner_nxt  = rd_data_r;
        head_nxt   = ptr_inc(head_r);
        count_nxt  = count_r - CNT_W'(1);
        status_nxt = fhm_pkg::ST_HANDOFF;
      end else begin
        held_nxt   = 1'b0;
        owner_nxt  = '0;
        status_nxt = fhm_pkg::ST_FREED;
      end
    end
  end

  // wait ring memory
  always_ff @(posedge clk) begin
    if (exec_go && mem_we) begin
      mem[tail_r] <= req_task_r;
    end
    if (in_fire) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_unlock_r <= (in_tuser == fhm_pkg::REQ_UNLOCK);
      req_task_r   <= in_tdata[TW-1:0];
    end
    if (exec_go) begin
      out_status_r <= status_nxt;
      out_woken_r  <= woken_nxt;
      out_owner_r  <= held_nxt ? owner_nxt : '0;
      out_locked_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 1'b0;
      owner_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            held_r      <= held_nxt;
            owner_r     <= owner_nxt;
            head_r      <= head_nxt;
            tail_r      <= tail_nxt;
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_locked_r, out_owner_r, out_woken_r, out_status_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TASKS))
    else $error("wait count beyond ring depth");

  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (count_r == '0))
    else $error("waiters present on a free mutex");

  a_handoff_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == fhm_pkg::ST_HANDOFF)
      |-> (out_locked_r && out_owner_r == out_woken_r))
    else $error("handoff result does not name the new owner");

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> (state_r == S_IDLE) && out_valid_r)
    else $error("applied request did not produce a result");
`endif

endmodule
